FILE: hw/rtl/trpg_pkg.sv
// ----------------------------------------------------------------------------
// trpg_pkg
// Shared types and constants of the thick ring point generator.
// ----------------------------------------------------------------------------
package trpg_pkg;

  // Fixed field widths
  localparam int RAD_W   = 10;  // outer radius and radius state
  localparam int CIN_W   = 16;  // centre coordinate width
  localparam int OFS_W   = 12;  // signed octant offset width
  localparam int STEP_W  = 13;  // signed step increments
  localparam int ERR_W   = 14;  // signed midpoint decision term
  localparam int PTS_N   = 8;   // points per iteration
  localparam int IDX_W   = 3;   // point index width

  // Input function codes
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Reciprocal of 3 for the inner radius: floor(n / 3) = (n * RECIP3) >> RECIP3_SH
  localparam int RECIP3_SH = 17;
  localparam logic [15:0] RECIP3 = 16'd43691;

  // Snapshot of one iteration handed from the iterator to the point buffer
  typedef struct packed {
    logic                    load;
    logic signed [CIN_W-1:0] cx;
    logic signed [CIN_W-1:0] cy;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic                    done;
  } pts_load_t;

endpackage

FILE: hw/rtl/trpg_iter.sv
// ----------------------------------------------------------------------------
// trpg_iter
// Ring state and one midpoint circle iteration per advance request.
// ----------------------------------------------------------------------------
module trpg_iter
  import trpg_pkg::*;
#(
  parameter int RADIUS_MAX = 1023
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_take,
  input  logic                    req_func,
  input  logic signed [CIN_W-1:0] req_cx,
  input  logic signed [CIN_W-1:0] req_cy,
  input  logic [RAD_W-1:0]        req_radius,
  output pts_load_t               load
);

  logic                     active_r, active_nxt;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic [RAD_W-1:0]         min_r, min_nxt;
  logic signed [OFS_W-1:0]  ox_r, ox_nxt;
  logic signed [OFS_W-1:0]  oy_r, oy_nxt;
  logic signed [STEP_W-1:0] dx_r, dx_nxt;
  logic signed [STEP_W-1:0] dy_r, dy_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [CIN_W-1:0]  cx_r, cx_nxt;
  logic signed [CIN_W-1:0]  cy_r, cy_nxt;

  logic [RAD_W-1:0]         r_clip;
  logic [RAD_W+16:0]        min_prod;
  logic [RAD_W-1:0]         min_start;
  logic                     e_le0, e_gt0, wrap, more;
  logic signed [ERR_W-1:0]  e1, e2;
  logic signed [OFS_W-1:0]  ox1, oy1;
  logic signed [STEP_W-1:0] dx1, dy1;
  logic [RAD_W-1:0]         rad_dec;
  logic                     done;

  // Clip start radius and derive the inner radius as 2r/3
  always_comb begin
    if ({2'b00, req_radius} > 12'(RADIUS_MAX)) begin
      r_clip = RAD_W'(RADIUS_MAX);
    end else begin
      r_clip = req_radius;
    end
    min_prod  = {r_clip, 1'b0} * RECIP3;
    min_start = min_prod[RECIP3_SH +: RAD_W];
  end

  // One midpoint step on the current octant
  always_comb begin
    e_le0 = (err_r <= 14'sd0);
    e1    = e_le0 ? err_r + {dy_r[STEP_W-1], dy_r} : err_r;
    oy1   = e_le0 ? oy_r + 12'sd1 : oy_r;
    dy1   = e_le0 ? dy_r + 13'sd2 : dy_r;
    e_gt0 = (e1 > 14'sd0);
    dx1   = e_gt0 ? dx_r + 13'sd2 : dx_r;
    ox1   = e_gt0 ? ox_r - 12'sd1 : ox_r;
    e2    = e_gt0 ? e1 + {dx1[STEP_W-1], dx1} - $signed({3'b000, rad_r, 1'b0}) : e1;
    wrap  = (ox1 < oy1);
    rad_dec = rad_r - 1'b1;
    more  = (rad_dec > min_r);
  end

  // Next state for start and advance requests
  always_comb begin
    active_nxt = active_r;
    rad_nxt    = rad_r;
    min_nxt    = min_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    err_nxt    = err_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    done       = 1'b0;
    if (req_take && req_func == FUNC_START) begin
      cx_nxt     = req_cx;
      cy_nxt     = req_cy;
      rad_nxt    = r_clip;
      min_nxt    = min_start;
      active_nxt = (r_clip > min_start);
      if (r_clip > min_start) begin
        ox_nxt  = $signed({2'b00, r_clip}) - 12'sd1;
        oy_nxt  = '0;
        dx_nxt  = 13'sd1;
        dy_nxt  = 13'sd1;
        err_nxt = 14'sd1 - $signed({3'b000, r_clip, 1'b0});
      end
    end else if (req_take && active_r) begin
      ox_nxt  = ox1;
      oy_nxt  = oy1;
      dx_nxt  = dx1;
      dy_nxt  = dy1;
      err_nxt = e2;
      if (wrap) begin
        rad_nxt = rad_dec;
        if (more) begin
          ox_nxt  = $signed({2'b00, rad_dec}) - 12'sd1;
          oy_nxt  = '0;
          dx_nxt  = 13'sd1;
          dy_nxt  = 13'sd1;
          err_nxt = 14'sd1 - $signed({3'b000, rad_dec, 1'b0});
        end else begin
          active_nxt = 1'b0;
          done       = 1'b1;
        end
      end
    end
  end

  // Hand the pre-step offsets to the point buffer
  always_comb begin
    load.load = req_take && (req_func == FUNC_ADVANCE) && active_r;
    load.cx   = cx_r;
    load.cy   = cy_r;
    load.ox   = ox_r;
    load.oy   = oy_r;
    load.done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rad_r    <= '0;
      min_r    <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else begin
      active_r <= active_nxt;
      rad_r    <= rad_nxt;
      min_r    <= min_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      err_r    <= err_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
    end
  end

endmodule

FILE: hw/rtl/trpg_emit.sv
// ----------------------------------------------------------------------------
// trpg_emit
// Saturates the eight octant points of one iteration and sends them out.
// ----------------------------------------------------------------------------
module trpg_emit
  import trpg_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pts_load_t                    load,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_px,
  output logic signed [COORD_BITS-1:0] out_py,
  output logic                         out_last,
  output logic                         out_ring_done
);

  localparam logic signed [32:0] C_HI = (33'sd1 <<< (COORD_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] C_LO = -C_HI - 33'sd1;

  logic                         busy_r, busy_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic                         done_r;
  logic signed [COORD_BITS-1:0] xs_r [4];
  logic signed [COORD_BITS-1:0] ys_r [4];
  logic signed [COORD_BITS-1:0] xs_nxt [4];
  logic signed [COORD_BITS-1:0] ys_nxt [4];
  logic                         take;

  function automatic logic signed [COORD_BITS-1:0] sat_add(
    input logic signed [CIN_W-1:0] c,
    input logic signed [OFS_W-1:0] o,
    input logic                    neg
  );
    logic signed [CIN_W:0] s;
    logic signed [32:0]    w;
    logic signed [32:0]    q;
    begin
      if (neg) begin
        s = {c[CIN_W-1], c} - {{(CIN_W+1-OFS_W){o[OFS_W-1]}}, o};
      end else begin
        s = {c[CIN_W-1], c} + {{(CIN_W+1-OFS_W){o[OFS_W-1]}}, o};
      end
      w = {{(33-CIN_W-1){s[CIN_W]}}, s};
      if (w > C_HI) begin
        q = C_HI;
      end else if (w < C_LO) begin
        q = C_LO;
      end else begin
        q = w;
      end
      return q[COORD_BITS-1:0];
    end
  endfunction

  // Saturated coordinates: x by {offset, sign}, y by {octant half, sign}
  always_comb begin
    xs_nxt[0] = sat_add(load.cx, load.ox, 1'b0);
    xs_nxt[1] = sat_add(load.cx, load.ox, 1'b1);
    xs_nxt[2] = sat_add(load.cx, load.oy, 1'b0);
    xs_nxt[3] = sat_add(load.cx, load.oy, 1'b1);
    ys_nxt[0] = sat_add(load.cy, load.oy, 1'b1);
    ys_nxt[1] = sat_add(load.cy, load.oy, 1'b0);
    ys_nxt[2] = sat_add(load.cy, load.ox, 1'b1);
    ys_nxt[3] = sat_add(load.cy, load.ox, 1'b0);
  end

  assign take          = busy_r && out_ready;
  assign free          = !busy_r || (take && idx_r == IDX_W'(PTS_N - 1));
  assign out_valid     = busy_r;
  assign out_px        = xs_r[idx_r[2:1]];
  assign out_py        = ys_r[{idx_r[2], idx_r[0]}];
  assign out_last      = (idx_r == IDX_W'(PTS_N - 1));
  assign out_ring_done = out_last && done_r;

  // Advance the point index, refill on load
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (take) begin
      if (idx_r == IDX_W'(PTS_N - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Hold the point set until the next load
  always_ff @(posedge clk) begin
    if (load.load) begin
      done_r <= load.done;
      for (int i = 0; i < 4; i++) begin
        xs_r[i] <= xs_nxt[i];
        ys_r[i] <= ys_nxt[i];
      end
    end
  end

endmodule

FILE: hw/rtl/thick_ring_point_generator.sv
// ----------------------------------------------------------------------------
// thick_ring_point_generator
// Thick ring rasterizer: each advance request runs one midpoint circle step
// and sends the eight octant points, stepping the radius down to 2r/3.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake             | payload
//   in_      | input     | in_valid / in_ready   | func, center_x, center_y, outer_radius
//   out_     | output    | out_valid / out_ready | px, py, last, ring_done
//
// A start request updates the ring state and sends nothing.
// An advance request is computed in the cycle it is taken; its eight points
// leave the point buffer one per cycle while out_ready is high, so the next advance
// waits for the buffer to drain, paced by the output port. in_ready rises again in
// the cycle the last buffered point is taken. Reset (rst_n low at a clock edge) clears
// the ring and the buffer; out_ready low holds the current point in place.
// ----------------------------------------------------------------------------
module thick_ring_point_generator
  import trpg_pkg::*;
#(
  parameter int RADIUS_MAX = 1023,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [CIN_W-1:0]      in_center_x,
  input  logic signed [CIN_W-1:0]      in_center_y,
  input  logic [RAD_W-1:0]             in_outer_radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_px,
  output logic signed [COORD_BITS-1:0] out_py,
  output logic                         out_last,
  output logic                         out_ring_done
);

  pts_load_t load;
  logic      free;

  // Take a request whenever the point buffer can refill
  assign in_ready = free;

  trpg_iter #(
    .RADIUS_MAX(RADIUS_MAX)
  ) u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_take   (in_valid && free),
    .req_func   (in_func),
    .req_cx     (in_center_x),
    .req_cy     (in_center_y),
    .req_radius (in_outer_radius),
    .load       (load)
  );

  trpg_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_px        (out_px),
    .out_py        (out_py),
    .out_last      (out_last),
    .out_ring_done (out_ring_done)
  );

endmodule
